@@ src/sttok_pkg.sv @@
// ----------------------------------------------------------------------------
// sttok_pkg
// Shared types, character codes and lookup functions for the source text
// tokenizer.
// ----------------------------------------------------------------------------
package sttok_pkg;

    localparam int KEYWORD_CHARS = 6;
    localparam int KW_IDX_W      = $clog2(KEYWORD_CHARS);
    localparam int KW_COUNT      = 7;
    localparam int POS_W         = 16;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW       = FIFO_AW + 1;

    localparam logic [POS_W-1:0] POS_CAP = 16'hffff;
    localparam logic [POS_W-1:0] WL_CAP  = 16'hffff;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5a;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7a;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    typedef enum logic [4:0] {
        K_ILLEGAL   = 5'd0,
        K_END       = 5'd1,
        K_IDENT     = 5'd2,
        K_INT       = 5'd3,
        K_ASSIGN    = 5'd4,
        K_SEMI      = 5'd5,
        K_LPAREN    = 5'd6,
        K_RPAREN    = 5'd7,
        K_LBRACE    = 5'd8,
        K_RBRACE    = 5'd9,
        K_COMMA     = 5'd10,
        K_PLUS      = 5'd11,
        K_MINUS     = 5'd12,
        K_BANG      = 5'd13,
        K_STAR      = 5'd14,
        K_SLASH     = 5'd15,
        K_LT        = 5'd16,
        K_GT        = 5'd17,
        K_EQ        = 5'd18,
        K_NOTEQ     = 5'd19,
        K_KW_LET    = 5'd20,
        K_KW_TRUE   = 5'd21,
        K_KW_FALSE  = 5'd22,
        K_KW_IF     = 5'd23,
        K_KW_ELSE   = 5'd24,
        K_KW_RETURN = 5'd25,
        K_KW_FN     = 5'd26
    } kind_t;

    typedef enum logic [2:0] {
        PC_NONE  = 3'd0,
        PC_INT   = 3'd1,
        PC_IDENT = 3'd2,
        PC_EQ    = 3'd3,
        PC_BANG  = 3'd4
    } pclass_t;

    typedef logic [KEYWORD_CHARS-1:0][7:0] word_buf_t;

    typedef struct packed {
        kind_t            kind;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] length;
        logic             last;
    } tok_t;

    typedef struct packed {
        logic a_vld;
        tok_t a;
        logic b_vld;
        tok_t b;
    } push_t;

    function automatic logic [3:0] kw_len(input logic [2:0] k);
        logic [3:0] n;
        case (k)
            3'd0:    n = 4'd3;
            3'd1:    n = 4'd4;
            3'd2:    n = 4'd5;
            3'd3:    n = 4'd2;
            3'd4:    n = 4'd4;
            3'd5:    n = 4'd6;
            3'd6:    n = 4'd2;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // byte 0 of the word holds the first letter
    function automatic word_buf_t kw_text(input logic [2:0] k);
        word_buf_t t;
        case (k)
            3'd0:    t = word_buf_t'({8'h74, 8'h65, 8'h6c});
            3'd1:    t = word_buf_t'({8'h65, 8'h75, 8'h72, 8'h74});
            3'd2:    t = word_buf_t'({8'h65, 8'h73, 8'h6c, 8'h61, 8'h66});
            3'd3:    t = word_buf_t'({8'h66, 8'h69});
            3'd4:    t = word_buf_t'({8'h65, 8'h73, 8'h6c, 8'h65});
            3'd5:    t = word_buf_t'({8'h6e, 8'h72, 8'h75, 8'h74, 8'h65, 8'h72});
            3'd6:    t = word_buf_t'({8'h6e, 8'h66});
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic kind_t kw_kind(input word_buf_t wb, input logic [POS_W-1:0] len);
        kind_t     r;
        logic      same;
        word_buf_t txt;
        r = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            txt  = kw_text(3'(k));
            same = (len == POS_W'(kw_len(3'(k))));
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
                if (i < int'(kw_len(3'(k))) && wb[i] != txt[i]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                r = kind_t'(5'(K_KW_LET) + 5'(k));
            end
        end
        return r;
    endfunction

    function automatic kind_t op_kind(input logic [7:0] c);
        kind_t r;
        case (c)
            CH_EQ:     r = K_ASSIGN;
            CH_SEMI:   r = K_SEMI;
            CH_LPAREN: r = K_LPAREN;
            CH_RPAREN: r = K_RPAREN;
            CH_LBRACE: r = K_LBRACE;
            CH_RBRACE: r = K_RBRACE;
            CH_COMMA:  r = K_COMMA;
            CH_PLUS:   r = K_PLUS;
            CH_MINUS:  r = K_MINUS;
            CH_BANG:   r = K_BANG;
            CH_STAR:   r = K_STAR;
            CH_SLASH:  r = K_SLASH;
            CH_LT:     r = K_LT;
            CH_GT:     r = K_GT;
            default:   r = K_ILLEGAL;
        endcase
        return r;
    endfunction

endpackage

@@ src/sttok_lexer.sv @@
// ----------------------------------------------------------------------------
// sttok_lexer
// Input byte register and one-step lexer: closes or extends the pending
// token and produces up to two tokens per byte.
// ----------------------------------------------------------------------------
module sttok_lexer
    import sttok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] ch,
    input  logic       room,
    output push_t      push
);

    logic             full_reg;
    logic [7:0]       ch_reg;
    pclass_t          pc_reg, pc_next;
    logic [POS_W-1:0] ts_reg, ts_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] wl_reg, wl_next;
    word_buf_t        word_buf_reg;

    logic                step;
    logic                is_digit, is_alpha, is_space;
    logic                extend, pair;
    logic [POS_W-1:0]    pos_inc, run_len;
    logic                buf_we;
    logic [KW_IDX_W-1:0] buf_idx;

    assign step     = full_reg && room;
    assign in_stall = full_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            full_reg <= 1'b1;
        end
        else if (step)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            ch_reg <= ch;
        end
        if (buf_we)
        begin
            word_buf_reg[buf_idx] <= ch_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= PC_NONE;
            ts_reg  <= '0;
            pos_reg <= '0;
            wl_reg  <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            ts_reg  <= ts_next;
            pos_reg <= pos_next;
            wl_reg  <= wl_next;
        end
    end

    assign is_digit = ch_reg inside {[CH_0:CH_9]};
    assign is_alpha = ch_reg inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ]};
    assign is_space = ch_reg inside {CH_SPACE, [CH_TAB:CH_CR]};
    assign extend   = (pc_reg == PC_INT && is_digit) || (pc_reg == PC_IDENT && is_alpha);
    assign pair     = (pc_reg == PC_EQ || pc_reg == PC_BANG) && ch_reg == CH_EQ;
    assign pos_inc  = (pos_reg == POS_CAP) ? pos_reg : pos_reg + 1'b1;
    assign run_len  = pos_reg - ts_reg;

    // next state
    always_comb
    begin
        pc_next  = pc_reg;
        ts_next  = ts_reg;
        pos_next = pos_reg;
        wl_next  = wl_reg;
        buf_we   = 1'b0;
        buf_idx  = wl_reg[KW_IDX_W-1:0];
        if (step)
        begin
            if (extend)
            begin
                pos_next = pos_inc;
                if (pc_reg == PC_IDENT)
                begin
                    buf_we  = wl_reg < POS_W'(KEYWORD_CHARS);
                    wl_next = (wl_reg == WL_CAP) ? wl_reg : wl_reg + 1'b1;
                end
            end
            else if (pair)
            begin
                pc_next  = PC_NONE;
                pos_next = pos_inc;
            end
            else if (ch_reg == CH_NUL)
            begin
                pc_next  = PC_NONE;
                ts_next  = '0;
                pos_next = '0;
                wl_next  = '0;
            end
            else
            begin
                pc_next  = PC_NONE;
                pos_next = pos_inc;
                if (is_digit)
                begin
                    pc_next = PC_INT;
                    ts_next = pos_reg;
                end
                else if (is_alpha)
                begin
                    pc_next = PC_IDENT;
                    ts_next = pos_reg;
                    buf_we  = 1'b1;
                    buf_idx = '0;
                    wl_next = POS_W'(1);
                end
                else if (ch_reg == CH_EQ)
                begin
                    pc_next = PC_EQ;
                    ts_next = pos_reg;
                end
                else if (ch_reg == CH_BANG)
                begin
                    pc_next = PC_BANG;
                    ts_next = pos_reg;
                end
            end
        end
    end

    // token outputs
    always_comb
    begin
        push.a_vld    = step && !extend && pc_reg != PC_NONE;
        push.a.start  = ts_reg;
        push.a.last   = 1'b0;
        push.a.kind   = K_INT;
        push.a.length = run_len;
        case (pc_reg)
            PC_IDENT:
            begin
                push.a.kind = kw_kind(word_buf_reg, wl_reg);
            end
            PC_EQ:
            begin
                push.a.kind   = pair ? K_EQ : K_ASSIGN;
                push.a.length = pair ? POS_W'(2) : POS_W'(1);
            end
            PC_BANG:
            begin
                push.a.kind   = pair ? K_NOTEQ : K_BANG;
                push.a.length = pair ? POS_W'(2) : POS_W'(1);
            end
            default:
            begin
                push.a.kind = K_INT;
            end
        endcase

        push.b_vld    = 1'b0;
        push.b.start  = pos_reg;
        push.b.length = POS_W'(1);
        push.b.last   = 1'b0;
        push.b.kind   = op_kind(ch_reg);
        if (step && !extend && !pair)
        begin
            if (ch_reg == CH_NUL)
            begin
                push.b_vld    = 1'b1;
                push.b.kind   = K_END;
                push.b.length = '0;
                push.b.last   = 1'b1;
            end
            else if (!(is_space || is_digit || is_alpha || ch_reg == CH_EQ
                       || ch_reg == CH_BANG))
            begin
                push.b_vld = 1'b1;
            end
        end
    end

endmodule

@@ src/sttok_fifo.sv @@
// ----------------------------------------------------------------------------
// sttok_fifo
// Four-entry token queue: takes up to two tokens a cycle, hands out one
// word a cycle on the output channel while out_stall is low.
// ----------------------------------------------------------------------------
module sttok_fifo
    import sttok_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  push_t             push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_stall,
    output tok_t              tok
);

    tok_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg, rptr_reg;
    logic [FIFO_CW-1:0] count_reg;

    logic               pop;
    logic               w0_en, w1_en;
    tok_t               w0_data;
    logic [FIFO_AW-1:0] wptr_1;
    logic [FIFO_CW-1:0] n_push;

    assign room      = count_reg < FIFO_CW'(FIFO_DEPTH - 1);
    assign out_valid = count_reg != '0;
    assign pop       = out_valid && !out_stall;
    assign tok       = mem[rptr_reg];

    assign w0_en   = push.a_vld || push.b_vld;
    assign w0_data = push.a_vld ? push.a : push.b;
    assign w1_en   = push.a_vld && push.b_vld;
    assign wptr_1  = wptr_reg + 1'b1;
    assign n_push  = FIFO_CW'(w0_en) + FIFO_CW'(w1_en);

    always_ff @(posedge clk)
    begin
        if (w0_en)
        begin
            mem[wptr_reg] <= w0_data;
        end
        if (w1_en)
        begin
            mem[wptr_1] <= push.b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_reg + FIFO_AW'(n_push);
            rptr_reg  <= rptr_reg + FIFO_AW'(pop);
            count_reg <= count_reg + n_push - FIFO_CW'(pop);
        end
    end

endmodule

@@ src/source_text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: source bytes in, tokens with kind, start and length out.
// ----------------------------------------------------------------------------
//   channel | signals                               | word
//   input   | in_valid, in_stall, ch                | one source byte
//   output  | out_valid, out_stall, kind, start_res,| one token
//           | length, last                          |
//
// one byte per cycle while in_stall is low; a byte is captured in the input
// register, then the lexer step pushes its tokens into a four-entry queue
// a byte that closes one token and makes a one-byte or end token gives two
// tokens, so the one-word-per-cycle output port sets the rate on such runs
// in_stall rises while a byte waits and the queue holds more than two tokens
// reset clears position and pending token; no clearing pass
module source_text_tokenizer
    import sttok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  kind,
    output logic [15:0] start_res,
    output logic [15:0] length,
    output logic        last
);

    push_t push;
    logic  room;
    tok_t  tok;

    sttok_lexer u_lexer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ch       (ch),
        .room     (room),
        .push     (push)
    );

    sttok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tok       (tok)
    );

    assign kind      = tok.kind;
    assign start_res = tok.start;
    assign length    = tok.length;
    assign last      = tok.last;

endmodule

@@ src/sttok_checker.sv @@
// ----------------------------------------------------------------------------
// sttok_checker
// Port-level checks on the tokenizer output channel.
// ----------------------------------------------------------------------------
module sttok_checker
    import sttok_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [4:0]  kind,
    input logic [15:0] start_res,
    input logic [15:0] length,
    input logic        last
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(start_res)
            && $stable(length) && $stable(last))
        else $error("stalled output word changed");

    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (kind == K_END)) && (!last || length == '0))
        else $error("last flag and end token disagree");

    a_pair_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == K_EQ || kind == K_NOTEQ) |-> length == 16'd2)
        else $error("two-char operator with wrong length");

    a_op_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind >= K_ASSIGN && kind <= K_GT |-> length == 16'd1)
        else $error("single-char operator with wrong length");

endmodule

bind source_text_tokenizer sttok_checker u_checker (.*);

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for source_text_tokenizer. Source bytes go in through
// the valid/stall input channel; each token out is compared field by field
// against an in-bench lexer or a pinned token. A short directed table covers
// the extremes. Random texts built from keywords, identifiers, numbers,
// operators, whitespace and stray bytes come last. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    import sttok_pkg::*;

    localparam int RAND_BYTES = 1600;

    typedef struct {
        string txt;
        bit    eot;
        bit    pinned;
        tok_t  tok;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  ch;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  kind;
    logic [15:0] start_res;
    logic [15:0] length;
    logic        last;

    // lexer state
    pclass_t     lx_pend;
    logic [15:0] lx_start;
    logic [15:0] lx_pos;
    logic [15:0] lx_wlen;
    logic [7:0]  lx_word [KEYWORD_CHARS];

    tok_t step_toks [$];
    tok_t due_tokens [$];

    bit calm;
    int bytes_fed;
    int tokens_checked;
    int texts_done;
    int mismatches;

    string kw_names [KW_COUNT] = '{"let", "true", "false", "if", "else", "return", "fn"};
    string op_chars            = "=;(){},+-!*/<>";
    string space_chars         = " \t\n\013\014\015";

    dir_row_t dir_rows [12] = '{
        '{"#",      1'b0, 1'b1, '{K_ILLEGAL, 16'd0, 16'd1, 1'b0}},
        '{";",      1'b0, 1'b1, '{K_SEMI,    16'd1, 16'd1, 1'b0}},
        '{"\377",   1'b0, 1'b1, '{K_ILLEGAL, 16'd2, 16'd1, 1'b0}},
        '{"",       1'b1, 1'b1, '{K_END,     16'd3, 16'd0, 1'b1}},
        '{"let true false if else return fn", 1'b1, 1'b0, '0},
        '{"=;(){},+-!*/<>",                   1'b1, 1'b0, '0},
        '{"a==b!=c= =!\t!x",                  1'b1, 1'b0, '0},
        '{"\013\014\015\n 007 Return LETS elsewhere iff f", 1'b1, 1'b0, '0},
        '{"99",     1'b1, 1'b0, '0},
        '{"!",      1'b1, 1'b0, '0},
        '{"=",      1'b1, 1'b0, '0},
        '{"\200\177@[`~", 1'b1, 1'b0, '0}
    };

    source_text_tokenizer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .start_res (start_res),
        .length    (length),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(CH_LA + r) : 8'(CH_UA + r - 26);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    function automatic logic [15:0] step_pos(input logic [15:0] p);
        return (p == POS_CAP) ? p : p + 16'd1;
    endfunction

    function automatic void emit(input kind_t k, input logic [15:0] s,
                                 input logic [15:0] n, input logic l);
        tok_t t;
        t.kind   = k;
        t.start  = s;
        t.length = n;
        t.last   = l;
        step_toks.push_back(t);
    endfunction

    // one lexer step; tokens land in step_toks
    task automatic lex_byte(input logic [7:0] c);
        logic [15:0] p;
        kind_t       wk;
        bit          same;
        p = lx_pos;
        step_toks.delete();
        case (lx_pend)
            PC_INT:
            begin
                if (is_digit(c))
                begin
                    lx_pos = step_pos(p);
                    return;
                end
                emit(K_INT, lx_start, p - lx_start, 1'b0);
            end
            PC_IDENT:
            begin
                if (is_alpha(c))
                begin
                    if (lx_wlen < KEYWORD_CHARS)
                        lx_word[lx_wlen] = c;
                    if (lx_wlen != WL_CAP)
                        lx_wlen++;
                    lx_pos = step_pos(p);
                    return;
                end
                wk = K_IDENT;
                if (lx_wlen <= KEYWORD_CHARS)
                begin
                    for (int k = 0; k < KW_COUNT; k++)
                    begin
                        if (wk == K_IDENT && kw_names[k].len() == lx_wlen)
                        begin
                            same = 1'b1;
                            for (int i = 0; i < kw_names[k].len(); i++)
                                if (lx_word[i] != kw_names[k][i])
                                    same = 1'b0;
                            if (same)
                                wk = kind_t'(5'(K_KW_LET) + 5'(k));
                        end
                    end
                end
                emit(wk, lx_start, p - lx_start, 1'b0);
            end
            PC_EQ, PC_BANG:
            begin
                if (c == CH_EQ)
                begin
                    emit((lx_pend == PC_EQ) ? K_EQ : K_NOTEQ, lx_start, 16'd2, 1'b0);
                    lx_pend = PC_NONE;
                    lx_pos  = step_pos(p);
                    return;
                end
                emit((lx_pend == PC_EQ) ? K_ASSIGN : K_BANG, lx_start, 16'd1, 1'b0);
            end
            default:
                ;
        endcase
        lx_pend = PC_NONE;

        if (c == CH_NUL)
        begin
            emit(K_END, p, 16'd0, 1'b1);
            lx_pos   = '0;
            lx_start = '0;
            lx_wlen  = '0;
            return;
        end
        lx_pos = step_pos(p);
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
            return;
        if (is_digit(c))
        begin
            lx_pend  = PC_INT;
            lx_start = p;
            return;
        end
        if (is_alpha(c))
        begin
            lx_pend    = PC_IDENT;
            lx_start   = p;
            lx_word[0] = c;
            lx_wlen    = 16'd1;
            return;
        end
        if (c == CH_EQ || c == CH_BANG)
        begin
            lx_pend  = (c == CH_EQ) ? PC_EQ : PC_BANG;
            lx_start = p;
            return;
        end
        for (int k = 0; k < op_chars.len(); k++)
        begin
            if (op_chars[k] == c)
            begin
                emit(kind_t'(5'(K_ASSIGN) + 5'(k)), p, 16'd1, 1'b0);
                return;
            end
        end
        emit(K_ILLEGAL, p, 16'd1, 1'b0);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit pinned = 1'b0,
                             input tok_t pinned_tok = '0);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        ch       <= b;
        do
            @(posedge clk);
        while (in_stall);
        lex_byte(b);
        if (pinned)
            due_tokens.push_back(pinned_tok);
        else
            foreach (step_toks[i])
                due_tokens.push_back(step_toks[i]);
        bytes_fed++;
    endtask

    // receiver idling
    initial
    begin
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!calm && $urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        tok_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_tokens.size() == 0)
            begin
                $error("unexpected token: kind %0d start %0d length %0d last %0d",
                       kind, start_res, length, last);
                mismatches++;
            end
            else
            begin
                want = due_tokens.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, kind);
                    mismatches++;
                end
                if (start_res !== want.start)
                begin
                    $error("start_res: expected %0d, actual %0d", want.start, start_res);
                    mismatches++;
                end
                if (length !== want.length)
                begin
                    $error("length: expected %0d, actual %0d", want.length, length);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    mismatches++;
                end
                tokens_checked++;
                if (want.last)
                    texts_done++;
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("timeout with %0d tokens still due", due_tokens.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int    pieces;
        int    pick;
        int    n;
        int    rand_from;
        string w;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        ch             = 8'h00;
        calm           = 1'b0;
        bytes_fed      = 0;
        tokens_checked = 0;
        texts_done     = 0;
        mismatches     = 0;
        lx_pend        = PC_NONE;
        lx_start       = '0;
        lx_pos         = '0;
        lx_wlen        = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[r])
        begin
            for (int i = 0; i < dir_rows[r].txt.len(); i++)
                send_byte(dir_rows[r].txt[i], dir_rows[r].pinned, dir_rows[r].tok);
            if (dir_rows[r].eot)
                send_byte(CH_NUL, dir_rows[r].pinned, dir_rows[r].tok);
        end

        rand_from = bytes_fed;
        while (bytes_fed < rand_from + RAND_BYTES)
        begin
            if ($urandom_range(0, 5) == 0)
                calm = ~calm;
            pieces = $urandom_range(1, 24);
            for (int t = 0; t < pieces; t++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                begin
                    w = kw_names[$urandom_range(0, KW_COUNT - 1)];
                    for (int i = 0; i < w.len(); i++)
                        send_byte(w[i]);
                end
                else if (pick < 35)
                begin
                    n = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 12)
                                                     : $urandom_range(1, 6);
                    for (int i = 0; i < n; i++)
                        send_byte(rand_letter());
                end
                else if (pick < 50)
                begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++)
                        send_byte(8'(CH_0 + $urandom_range(0, 9)));
                end
                else if (pick < 68)
                    send_byte(op_chars[$urandom_range(0, op_chars.len() - 1)]);
                else if (pick < 78)
                begin
                    send_byte($urandom_range(0, 1) ? CH_EQ : CH_BANG);
                    send_byte(CH_EQ);
                end
                else if (pick < 84)
                    send_byte($urandom_range(0, 1) ? CH_EQ : CH_BANG);
                else
                    send_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 1)
                    send_byte(space_chars[$urandom_range(0, space_chars.len() - 1)]);
            end
            send_byte(CH_NUL);
        end
        calm = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        while (due_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("fed %0d source bytes, checked %0d tokens across %0d texts",
                 bytes_fed, tokens_checked, texts_done);
        $display("directed table of %0d rows, then random texts with idling on both sides",
                 $size(dir_rows));
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
src/sttok_pkg.sv
src/sttok_lexer.sv
src/sttok_fifo.sv
src/source_text_tokenizer.sv
src/sttok_checker.sv
dv/tb.sv
